FILE: rtl/thkm_pkg.sv
// thkm_pkg: shared types and constants of the threshold k-mer enumerator
`timescale 1ns / 1ps
package thkm_pkg;

    localparam int SCORE_W = 24;
    localparam int CODE_W  = 32;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7FFFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;

    // operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_NEXT  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // register indexes, paddr[3:2]
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WINDOW    = 2'd1,
        REG_LENGTH    = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    // search sequencer
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_STEP = 2'd1,
        ST_FILL = 2'd2
    } state_t;

    // saturating add into the signed 24-bit range
    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        logic signed [SCORE_W:0] s;
        s = $signed({a[SCORE_W-1], a}) + $signed({b[SCORE_W-1], b});
        if (s > $signed({SCORE_MAX[SCORE_W-1], SCORE_MAX})) begin
            return SCORE_MAX;
        end else if (s < $signed({SCORE_MIN[SCORE_W-1], SCORE_MIN})) begin
            return SCORE_MIN;
        end
        return s[SCORE_W-1:0];
    endfunction

endpackage

FILE: rtl/thkm_ram.sv
// thkm_ram: generic single write port ram with registered read
`timescale 1ns / 1ps
module thkm_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/threshold_kmer_enumerator.sv
// threshold_kmer_enumerator: depth-first branch and bound k-mer search over a score matrix
// Load items write in-range cells of the matrix ram; a start issues one cell read and a fill.
// A next item runs search steps, and each cell read from the matrix ram (push or sibling)
// is followed by a fill; pruned subtrees add steps, so the steps of one next item have no fixed bound.
// Results sit in an output register; a new search step waits only when it must emit into it.
// aresetn (synchronous, active low) empties the search and restores the configuration and control registers; the
// matrix ram is not cleared and holds undefined cells until loaded.
`timescale 1ns / 1ps
module threshold_kmer_enumerator #(
    parameter int MAX_KMER       = 16,
    parameter int MATRIX_COLUMNS = 256,
    parameter int ALPHABET       = 4,
    parameter int LETTER_BITS    = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // column[7:0], rank[9:8], letter[11:10], cell_score[35:12]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // kmer_code[31:0], kmer_score[55:32]
    output logic        m_tuser,  // found[0]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW     = thkm_pkg::SCORE_W;
    localparam int CDW    = thkm_pkg::CODE_W;
    localparam int DW     = $clog2(MAX_KMER + 1);
    localparam int KW     = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;
    localparam int RW     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int CW     = $clog2(MATRIX_COLUMNS);
    localparam int CELLS  = MATRIX_COLUMNS * ALPHABET;
    localparam int AW     = $clog2(CELLS);
    localparam int MW     = LETTER_BITS + SW;
    localparam int RMW    = 18;

    typedef struct packed {
        logic [CDW-1:0]       code;
        logic signed [SW-1:0] score;
        logic [RW-1:0]        rank;
        logic                 visited;
    } level_t;

    // configuration registers
    logic signed [SW-1:0] thr_reg;
    logic [7:0]           ws_reg;
    logic [4:0]           klen_reg;

    // sequencer and path state
    thkm_pkg::state_t     state_reg, state_next;
    logic [DW-1:0]        depth_reg, depth_next;
    level_t               top_reg, top_next;
    level_t               stk_reg [MAX_KMER];
    logic                 stk_we;
    logic [KW-1:0]        stk_waddr;
    logic [CDW-1:0]       pcode_reg, pcode_next;
    logic signed [SW-1:0] pscore_reg, pscore_next;
    logic [RW-1:0]        frank_reg, frank_next;
    logic [DW-1:0]        fdepth_reg, fdepth_next;
    logic                 fret_reg, fret_next;

    // output register
    logic                 mval_reg, mval_next;
    logic                 found_reg, found_next;
    logic [CDW-1:0]       code_reg, code_next;
    logic signed [SW-1:0] oscore_reg, oscore_next;

    // matrix ram ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [MW-1:0]        ram_wdata, ram_rdata;

    // input fields
    logic [1:0]           in_op;
    logic [7:0]           in_col;
    logic [1:0]           in_rank;
    logic [1:0]           in_letter;
    logic signed [SW-1:0] in_score;

    assign in_op     = s_tuser;
    assign in_col    = s_tdata[7:0];
    assign in_rank   = s_tdata[9:8];
    assign in_letter = s_tdata[11:10];
    assign in_score  = s_tdata[35:12];

    // column wrap: restoring reduction by the column count, five narrow steps
    function automatic logic [CW-1:0] wrap_col(input logic [8:0] v);
        logic [RMW-1:0] rem;
        rem = {{(RMW-9){1'b0}}, v};
        for (int k = 4; k >= 0; k--) begin
            if (rem >= RMW'(MATRIX_COLUMNS << k)) begin
                rem = rem - RMW'(MATRIX_COLUMNS << k);
            end
        end
        return rem[CW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [8:0] v, input logic [RW-1:0] r);
        logic [AW-1:0] c;
        c = AW'(wrap_col(v));
        return AW'(c * AW'(ALPHABET)) + AW'(r);
    endfunction

    thkm_ram #(
        .WIDTH(MW),
        .DEPTH(CELLS)
    ) u_cells (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // register port
    logic                 cfg_wr;
    thkm_pkg::reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = thkm_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= thkm_pkg::SCORE_MIN;
            ws_reg   <= 8'd0;
            klen_reg <= 5'd8;
        end else if (cfg_wr) begin
            case (cfg_idx)
                thkm_pkg::REG_THRESHOLD: thr_reg  <= pwdata[SW-1:0];
                thkm_pkg::REG_WINDOW:    ws_reg   <= pwdata[7:0];
                thkm_pkg::REG_LENGTH:    klen_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            thkm_pkg::REG_THRESHOLD: prdata = {{(32-SW){thr_reg[SW-1]}}, thr_reg};
            thkm_pkg::REG_WINDOW:    prdata = {24'd0, ws_reg};
            thkm_pkg::REG_LENGTH:    prdata = {27'd0, klen_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // clamped k-mer length
    logic [DW-1:0] len_act;
    always_comb begin
        if (klen_reg == 5'd0) begin
            len_act = DW'(1);
        end else if (32'(klen_reg) > 32'(MAX_KMER)) begin
            len_act = DW'(MAX_KMER);
        end else begin
            len_act = DW'(klen_reg);
        end
    end

    // parent of the top level and step decisions
    level_t         parent;
    logic [KW-1:0]  top_idx;
    logic [KW-1:0]  par_idx;
    logic           above;
    logic           can_sib;
    logic           out_free;
    logic           accept;

    assign top_idx  = KW'(depth_reg - DW'(1));
    assign par_idx  = KW'(depth_reg - DW'(2));
    assign parent   = stk_reg[par_idx];
    assign above    = top_reg.score > thr_reg;
    assign can_sib  = 32'(top_reg.rank) + 32'd1 < 32'(ALPHABET);
    assign out_free = !mval_reg || m_tready;
    assign s_tready = (state_reg == thkm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // next state, ram access, path updates
    always_comb begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        top_next    = top_reg;
        pcode_next  = pcode_reg;
        pscore_next = pscore_reg;
        frank_next  = frank_reg;
        fdepth_next = fdepth_reg;
        fret_next   = fret_reg;
        mval_next   = mval_reg && !m_tready;
        found_next  = found_reg;
        code_next   = code_reg;
        oscore_next = oscore_reg;
        stk_we      = 1'b0;
        stk_waddr   = top_idx;
        ram_we      = 1'b0;
        ram_waddr   = cell_addr({1'b0, in_col}, RW'(in_rank));
        ram_wdata   = {in_letter[LETTER_BITS-1:0], in_score};
        ram_raddr   = cell_addr({1'b0, ws_reg}, RW'(0));

        case (state_reg)
            thkm_pkg::ST_IDLE: begin
                if (accept) begin
                    case (thkm_pkg::op_t'(in_op))
                        thkm_pkg::OP_LOAD: begin
                            ram_we = (32'(in_col) < 32'(MATRIX_COLUMNS))
                                  && (32'(in_rank) < 32'(ALPHABET));
                        end
                        thkm_pkg::OP_START: begin
                            pcode_next  = '0;
                            pscore_next = '0;
                            frank_next  = '0;
                            fdepth_next = DW'(1);
                            fret_next   = 1'b1;
                            state_next  = thkm_pkg::ST_FILL;
                        end
                        thkm_pkg::OP_NEXT: begin
                            state_next = thkm_pkg::ST_STEP;
                        end
                        default: ;
                    endcase
                end
            end
            thkm_pkg::ST_STEP: begin
                if (depth_reg == '0) begin
                    // search empty
                    if (out_free) begin
                        mval_next   = 1'b1;
                        found_next  = 1'b0;
                        code_next   = '0;
                        oscore_next = '0;
                        state_next  = thkm_pkg::ST_IDLE;
                    end
                end else if (!above
                          || (top_reg.visited && !can_sib && depth_reg <= len_act)
                          || (top_reg.visited && !can_sib && depth_reg > len_act)) begin
                    // prune or exhausted ranks: pop and mark parent visited,
                    // emitting first when the top is a finished k-mer
                    if (above && depth_reg >= len_act) begin
                        if (out_free) begin
                            mval_next   = 1'b1;
                            found_next  = 1'b1;
                            code_next   = top_reg.code;
                            oscore_next = top_reg.score;
                            state_next  = thkm_pkg::ST_IDLE;
                            depth_next  = depth_reg - DW'(1);
                            if (depth_reg > DW'(1)) begin
                                top_next         = parent;
                                top_next.visited = 1'b1;
                            end
                        end
                    end else begin
                        depth_next = depth_reg - DW'(1);
                        if (depth_reg > DW'(1)) begin
                            top_next         = parent;
                            top_next.visited = 1'b1;
                        end
                    end
                end else if (top_reg.visited) begin
                    // next sibling at the top level
                    ram_raddr   = cell_addr(9'(ws_reg) + 9'(top_idx), top_reg.rank + RW'(1));
                    pcode_next  = (depth_reg > DW'(1)) ? parent.code : '0;
                    pscore_next = (depth_reg > DW'(1)) ? parent.score : '0;
                    frank_next  = top_reg.rank + RW'(1);
                    fdepth_next = depth_reg;
                    if (depth_reg >= len_act) begin
                        if (out_free) begin
                            mval_next   = 1'b1;
                            found_next  = 1'b1;
                            code_next   = top_reg.code;
                            oscore_next = top_reg.score;
                            fret_next   = 1'b1;
                            state_next  = thkm_pkg::ST_FILL;
                        end
                    end else begin
                        fret_next  = 1'b0;
                        state_next = thkm_pkg::ST_FILL;
                    end
                end else if (depth_reg < len_act) begin
                    // descend: push the top and fill the next level with rank zero
                    stk_we      = 1'b1;
                    ram_raddr   = cell_addr(9'(ws_reg) + 9'(depth_reg), RW'(0));
                    pcode_next  = top_reg.code;
                    pscore_next = top_reg.score;
                    frank_next  = '0;
                    fdepth_next = depth_reg + DW'(1);
                    fret_next   = 1'b0;
                    state_next  = thkm_pkg::ST_FILL;
                end else begin
                    top_next.visited = 1'b1;
                end
            end
            thkm_pkg::ST_FILL: begin
                // cell data is valid: build the new top level
                top_next.code    = (pcode_next << LETTER_BITS)
                                 | CDW'(ram_rdata[MW-1:SW]);
                top_next.score   = thkm_pkg::sat_add(pscore_reg, ram_rdata[SW-1:0]);
                top_next.rank    = frank_reg;
                top_next.visited = 1'b0;
                depth_next       = fdepth_reg;
                state_next       = fret_reg ? thkm_pkg::ST_IDLE : thkm_pkg::ST_STEP;
            end
            default: state_next = thkm_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= thkm_pkg::ST_IDLE;
            depth_reg <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            mval_reg  <= mval_next;
        end
    end

    // payload registers and path stack
    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        pcode_reg  <= pcode_next;
        pscore_reg <= pscore_next;
        frank_reg  <= frank_next;
        fdepth_reg <= fdepth_next;
        fret_reg   <= fret_next;
        found_reg  <= found_next;
        code_reg   <= code_next;
        oscore_reg <= oscore_next;
        if (stk_we) begin
            stk_reg[stk_waddr] <= top_reg;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {oscore_reg, code_reg};

    // path depth never exceeds the deepest level
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) <= MAX_KMER)
        else $error("path depth out of range");

    // a fill always leaves a non-empty path
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == thkm_pkg::ST_FILL |=> depth_reg != '0)
        else $error("fill left an empty path");

    // an exhausted report carries zero payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        mval_reg && !found_reg |-> code_reg == '0 && oscore_reg == '0)
        else $error("exhausted report with payload");

    // a fill state is never followed by another fill state
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == thkm_pkg::ST_FILL |=> state_reg != thkm_pkg::ST_FILL)
        else $error("fill did not complete");

endmodule
